[rtl/core/iolh_pkg.sv]
// ----------------------------------------------------------------------------
// I/O latency histogram package
// Shared request, response and stage types plus register and mode codes.
// ----------------------------------------------------------------------------
package iolh_pkg;

   typedef enum logic [1:0] {
      MODE_OK      = 2'd0,
      MODE_FAILED  = 2'd1,
      MODE_INVALID = 2'd2,
      MODE_MERGED  = 2'd3
   } iolh_mode_type;

   localparam logic [2:0] TYPE_NONE = 3'd0;

   localparam logic [2:0] CSR_ACCT_FAILED  = 3'd0;
   localparam logic [2:0] CSR_ACCT_INVALID = 3'd1;
   localparam logic [2:0] CSR_BOUND_COUNT  = 3'd2;
   localparam logic [2:0] CSR_BOUND_A      = 3'd3;

   typedef struct packed {
      iolh_mode_type mode;
      logic [2:0]    io_type;
      logic [31:0]   byte_count;
      logic [63:0]   start_time;
      logic [63:0]   now_time;
      logic [15:0]   merge_count;
   } iolh_req_type;

   typedef struct packed {
      logic        ignored;
      logic        bin_hit;
      logic [2:0]  bin_index;
      logic [63:0] bin_value;
      logic [63:0] event_count;
      logic [63:0] byte_total;
      logic [63:0] time_total;
      logic [63:0] last_access;
   } iolh_rsp_type;

   typedef struct packed {
      iolh_mode_type mode;
      logic [2:0]    io_type;
      logic          drop;
      logic [31:0]   byte_count;
      logic [63:0]   latency;
      logic [63:0]   now_time;
      logic [15:0]   merge_count;
      logic          hist_en;
      logic [2:0]    bin;
   } iolh_stage_type;

endpackage

[rtl/core/iolh_bin_sel.sv]
// ----------------------------------------------------------------------------
// Latency and bin select
// Computes the request latency, the drop decision and the histogram bin.
// ----------------------------------------------------------------------------
module iolh_bin_sel #(
   parameter int NUM_TYPES  = 5,
   parameter int MAX_BOUNDS = 5,
   parameter int AW         = 5
) (
   input  iolh_pkg::iolh_req_type   req,
   input  logic [2:0]               bound_count,
   input  logic [63:0]              bounds [MAX_BOUNDS],
   output iolh_pkg::iolh_stage_type stage,
   output logic [AW-1:0]            slot
);

   localparam int TW    = $clog2(NUM_TYPES);
   localparam int SLOTS = MAX_BOUNDS + 1;

   logic [63:0]   lat;
   logic [2:0]    k;
   logic [2:0]    bin;
   logic          type_ok;
   logic          completion;
   logic          drop;
   logic [TW+2:0] t_ext;
   logic [TW-1:0] t;

   always_comb begin
      lat        = req.now_time - req.start_time;
      type_ok    = 32'(req.io_type) < NUM_TYPES;
      completion = (req.mode == iolh_pkg::MODE_OK) || (req.mode == iolh_pkg::MODE_FAILED);
      drop       = !type_ok || (req.io_type == iolh_pkg::TYPE_NONE && completion);
      t_ext      = (TW+3)'(req.io_type);
      t          = type_ok ? t_ext[TW-1:0] : '0;
      k          = (32'(bound_count) > MAX_BOUNDS) ? 3'(MAX_BOUNDS) : bound_count;
      bin        = k;
      for (int i = MAX_BOUNDS - 1; i >= 0; i--) begin
         if ((i < int'(k)) && (lat < bounds[i])) begin
            bin = 3'(i);
         end
      end
      slot = AW'(int'(t) * SLOTS + int'(bin));

      stage.mode        = req.mode;
      stage.io_type     = req.io_type;
      stage.drop        = drop;
      stage.byte_count  = req.byte_count;
      stage.latency     = lat;
      stage.now_time    = req.now_time;
      stage.merge_count = req.merge_count;
      stage.hist_en     = !drop && completion && (k != 3'd0);
      stage.bin         = bin;
   end

endmodule

[rtl/core/iolh_bin_ram.sv]
// ----------------------------------------------------------------------------
// Histogram bin count memory
// One write and one registered read port, per-entry valid bits and a
// write-to-read bypass for back-to-back updates of the same bin.
// ----------------------------------------------------------------------------
module iolh_bin_ram #(
   parameter int DEPTH = 30,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data
);

   logic [63:0] mem_ff [DEPTH];
   logic        vld_ff [DEPTH];
   logic [63:0] rd_data_ff;
   logic        rd_vld_ff;
   logic        fwd_ff;
   logic [63:0] fwd_data_ff;
   logic        fwd_in;

   assign fwd_in  = wr_en && (wr_addr == rd_addr);
   assign rd_data = fwd_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : 64'd0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
            fwd_ff    <= fwd_in;
         end
      end
   end

endmodule

[rtl/core/iolh_stats.sv]
// ----------------------------------------------------------------------------
// Per-type statistics counters
// Holds the op, byte and latency counters and the last access time, and
// builds the response for one request.
// ----------------------------------------------------------------------------
module iolh_stats #(
   parameter int NUM_TYPES = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  iolh_pkg::iolh_stage_type stage,
   input  logic                     acct_failed,
   input  logic                     acct_invalid,
   input  logic [63:0]              bin_rd,
   output logic                     bin_wr_en,
   output logic [63:0]              bin_wr_data,
   output iolh_pkg::iolh_rsp_type   rsp
);

   localparam int TW = $clog2(NUM_TYPES);

   logic [63:0] ok_ff      [NUM_TYPES];
   logic [63:0] failed_ff  [NUM_TYPES];
   logic [63:0] invalid_ff [NUM_TYPES];
   logic [63:0] merged_ff  [NUM_TYPES];
   logic [63:0] bytes_ff   [NUM_TYPES];
   logic [63:0] lat_ff     [NUM_TYPES];
   logic [63:0] last_ff;

   logic [TW+2:0] t_ext;
   logic [TW-1:0] t;
   logic          is_ok;
   logic          is_fail;
   logic          is_inv;
   logic          is_mrg;
   logic          take_time;
   logic          set_last;
   logic [63:0]   ok_in;
   logic [63:0]   failed_in;
   logic [63:0]   invalid_in;
   logic [63:0]   merged_in;
   logic [63:0]   bytes_in;
   logic [63:0]   lat_in;
   logic [63:0]   last_in;

   always_comb begin
      t_ext   = (TW+3)'(stage.io_type);
      t       = stage.drop ? '0 : t_ext[TW-1:0];
      is_ok   = 1'b0;
      is_fail = 1'b0;
      is_inv  = 1'b0;
      is_mrg  = 1'b0;
      unique case (stage.mode)
         iolh_pkg::MODE_OK:      is_ok   = !stage.drop;
         iolh_pkg::MODE_FAILED:  is_fail = !stage.drop;
         iolh_pkg::MODE_INVALID: is_inv  = !stage.drop;
         iolh_pkg::MODE_MERGED:  is_mrg  = !stage.drop;
         default:                is_ok   = 1'b0;
      endcase
      take_time = is_ok || (is_fail && acct_failed);
      set_last  = take_time || (is_inv && acct_invalid);

      ok_in      = ok_ff[t] + 64'd1;
      failed_in  = failed_ff[t] + 64'd1;
      invalid_in = invalid_ff[t] + 64'd1;
      merged_in  = merged_ff[t] + 64'(stage.merge_count);
      bytes_in   = is_ok ? bytes_ff[t] + 64'(stage.byte_count) : bytes_ff[t];
      lat_in     = take_time ? lat_ff[t] + stage.latency : lat_ff[t];
      last_in    = set_last ? stage.now_time : last_ff;

      bin_wr_en   = en && stage.hist_en;
      bin_wr_data = bin_rd + 64'd1;

      rsp.ignored     = stage.drop;
      rsp.bin_hit     = stage.hist_en;
      rsp.bin_index   = stage.hist_en ? stage.bin : 3'd0;
      rsp.bin_value   = stage.hist_en ? bin_wr_data : 64'd0;
      rsp.event_count = 64'd0;
      if (is_ok) begin
         rsp.event_count = ok_in;
      end else if (is_fail) begin
         rsp.event_count = failed_in;
      end else if (is_inv) begin
         rsp.event_count = invalid_in;
      end else if (is_mrg) begin
         rsp.event_count = merged_in;
      end
      rsp.byte_total  = stage.drop ? 64'd0 : bytes_in;
      rsp.time_total  = stage.drop ? 64'd0 : lat_in;
      rsp.last_access = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TYPES; i++) begin
            ok_ff[i]      <= 64'd0;
            failed_ff[i]  <= 64'd0;
            invalid_ff[i] <= 64'd0;
            merged_ff[i]  <= 64'd0;
            bytes_ff[i]   <= 64'd0;
            lat_ff[i]     <= 64'd0;
         end
         last_ff <= 64'd0;
      end else if (en) begin
         if (is_ok) begin
            ok_ff[t] <= ok_in;
         end
         if (is_fail) begin
            failed_ff[t] <= failed_in;
         end
         if (is_inv) begin
            invalid_ff[t] <= invalid_in;
         end
         if (is_mrg) begin
            merged_ff[t] <= merged_in;
         end
         bytes_ff[t] <= bytes_in;
         lat_ff[t]   <= lat_in;
         last_ff     <= last_in;
      end
   end

endmodule

[rtl/core/io_latency_histogram_accounting.sv]
// ----------------------------------------------------------------------------
// I/O latency histogram accounting
// Per-type completion statistics with a per-type latency histogram.
// ----------------------------------------------------------------------------
// Each request on the req_ channel describes one completion, invalid request
// or merged batch. The block answers every request with exactly one response
// on the rsp_ channel carrying the updated counters and histogram bin.
// A request moves through an input register, a bin select stage that reads
// the bin count memory, and an update stage that writes the result register.
// The response is registered behind the input and stage registers, and one
// request is accepted every cycle while the receiver takes responses.
// The bin count memory has one read and one write port, and back-to-back
// updates of the same bin are bypassed around it.
// When rsp_stall holds a waiting response, the whole pipeline holds and
// req_stall rises until the response is taken.
// Reset clears all counters, the histogram valid bits and the pipeline, and
// loads both accounting switches with one and the other registers with zero.
// The user must write the csr_ port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module io_latency_histogram_accounting #(
   parameter int NUM_TYPES  = 5,
   parameter int MAX_BOUNDS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  iolh_pkg::iolh_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output iolh_pkg::iolh_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_wdata
);

   localparam int DEPTH = NUM_TYPES * (MAX_BOUNDS + 1);
   localparam int AW    = $clog2(DEPTH);

   logic        acct_failed_ff;
   logic        acct_failed_in;
   logic        acct_invalid_ff;
   logic        acct_invalid_in;
   logic [2:0]  bound_count_ff;
   logic [2:0]  bound_count_in;
   logic [63:0] bounds_ff [MAX_BOUNDS];
   logic [63:0] bounds_in [MAX_BOUNDS];

   logic                     adv;
   logic                     s0_vld_ff;
   logic                     s0_vld_in;
   iolh_pkg::iolh_req_type   s0_ff;
   logic                     s1_vld_ff;
   logic                     s1_vld_in;
   iolh_pkg::iolh_stage_type s1_ff;
   iolh_pkg::iolh_stage_type s1_in;
   logic [AW-1:0]            slot_ff;
   logic [AW-1:0]            slot_in;
   logic                     rsp_vld_ff;
   logic                     rsp_vld_in;
   iolh_pkg::iolh_rsp_type   rsp_ff;
   iolh_pkg::iolh_rsp_type   rsp_in;
   logic [63:0]              bin_rd;
   logic                     bin_wr_en;
   logic [63:0]              bin_wr_data;

   always_comb begin
      acct_failed_in  = acct_failed_ff;
      acct_invalid_in = acct_invalid_ff;
      bound_count_in  = bound_count_ff;
      for (int i = 0; i < MAX_BOUNDS; i++) begin
         bounds_in[i] = bounds_ff[i];
      end
      if (csr_we) begin
         unique case (csr_index)
            iolh_pkg::CSR_ACCT_FAILED:  acct_failed_in  = csr_wdata[0];
            iolh_pkg::CSR_ACCT_INVALID: acct_invalid_in = csr_wdata[0];
            iolh_pkg::CSR_BOUND_COUNT:  bound_count_in  = csr_wdata[2:0];
            default: begin
               for (int i = 0; i < MAX_BOUNDS; i++) begin
                  if (csr_index == 3'(int'(iolh_pkg::CSR_BOUND_A) + i)) begin
                     bounds_in[i] = csr_wdata;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acct_failed_ff  <= 1'b1;
         acct_invalid_ff <= 1'b1;
         bound_count_ff  <= 3'd0;
         for (int i = 0; i < MAX_BOUNDS; i++) begin
            bounds_ff[i] <= 64'd0;
         end
      end else begin
         acct_failed_ff  <= acct_failed_in;
         acct_invalid_ff <= acct_invalid_in;
         bound_count_ff  <= bound_count_in;
         for (int i = 0; i < MAX_BOUNDS; i++) begin
            bounds_ff[i] <= bounds_in[i];
         end
      end
   end

   assign adv        = !(rsp_vld_ff && rsp_stall);
   assign req_stall  = !adv;
   assign s0_vld_in  = adv ? req_valid : s0_vld_ff;
   assign s1_vld_in  = adv ? s0_vld_ff : s1_vld_ff;
   assign rsp_vld_in = adv ? s1_vld_ff : rsp_vld_ff;
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff  <= s0_vld_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff   <= req_data;
         s1_ff   <= s1_in;
         slot_ff <= slot_in;
         if (s1_vld_ff) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   iolh_bin_sel #(
      .NUM_TYPES  (NUM_TYPES),
      .MAX_BOUNDS (MAX_BOUNDS),
      .AW         (AW)
   ) u_bin_sel (
      .req         (s0_ff),
      .bound_count (bound_count_ff),
      .bounds      (bounds_ff),
      .stage       (s1_in),
      .slot        (slot_in)
   );

   iolh_bin_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_bin_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (slot_in),
      .rd_data (bin_rd),
      .wr_en   (bin_wr_en),
      .wr_addr (slot_ff),
      .wr_data (bin_wr_data)
   );

   iolh_stats #(
      .NUM_TYPES (NUM_TYPES)
   ) u_stats (
      .clock        (clock),
      .reset        (reset),
      .en           (adv && s1_vld_ff),
      .stage        (s1_ff),
      .acct_failed  (acct_failed_ff),
      .acct_invalid (acct_invalid_ff),
      .bin_rd       (bin_rd),
      .bin_wr_en    (bin_wr_en),
      .bin_wr_data  (bin_wr_data),
      .rsp          (rsp_in)
   );

endmodule

[rtl/core/iolh_checker.sv]
// ----------------------------------------------------------------------------
// I/O latency histogram port checker
// Watches the request and response ports of the accounting block.
// ----------------------------------------------------------------------------
module iolh_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input iolh_pkg::iolh_rsp_type rsp_data
);

   // The response register is empty right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // The request side stalls only behind a held response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // A dropped request changes no counter and no bin.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ignored |->
         !rsp_data.bin_hit && rsp_data.event_count == 64'd0 &&
         rsp_data.byte_total == 64'd0 && rsp_data.time_total == 64'd0)
      else $error("dropped request reported counter values");

   // Without a histogram update the bin fields read as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bin_hit |->
         rsp_data.bin_index == 3'd0 && rsp_data.bin_value == 64'd0)
      else $error("bin fields set without a histogram update");

endmodule

bind io_latency_histogram_accounting iolh_checker u_iolh_checker (.*);

[sim/io_latency_histogram_accounting_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O latency histogram accounting testbench
// Drives completion, invalid and merged requests through the req_ channel
// under random idling and a long response hold-off, predicts every response
// from a shadow copy of the counters, histogram and registers, and compares
// each response field by field in arrival order.
// ----------------------------------------------------------------------------
module io_latency_histogram_accounting_tb;

   localparam int NUM_T = 5;
   localparam int MAX_B = 5;
   localparam int BIN_SLOTS = MAX_B + 1;
   localparam int LONG_HOLD = 300;
   localparam int IDLE_LIMIT = 2000;

   localparam logic [2:0] TYPE_READ        = 3'd1;
   localparam logic [2:0] TYPE_WRITE       = 3'd2;
   localparam logic [2:0] TYPE_FLUSH       = 3'd3;
   localparam logic [2:0] TYPE_UNMAP       = 3'd4;
   localparam logic [2:0] TYPE_UNKNOWN_LO  = 3'd5;
   localparam logic [2:0] TYPE_UNKNOWN_HI  = 3'd7;

   localparam logic [2:0] CSR_BOUND_B = iolh_pkg::CSR_BOUND_A + 3'd1;
   localparam logic [2:0] CSR_BOUND_C = iolh_pkg::CSR_BOUND_A + 3'd2;
   localparam logic [2:0] CSR_BOUND_D = iolh_pkg::CSR_BOUND_A + 3'd3;
   localparam logic [2:0] CSR_BOUND_E = iolh_pkg::CSR_BOUND_A + 3'd4;

   localparam logic [63:0] MAX_NS = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   iolh_pkg::iolh_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   iolh_pkg::iolh_rsp_type rsp_data;
   logic                   csr_we = 1'b0;
   logic [2:0]             csr_index = '0;
   logic [63:0]            csr_wdata = '0;

   logic no_idle = 1'b0;
   logic long_hold = 1'b0;
   int   errors = 0;

   logic        cfg_acct_failed = 1'b1;
   logic        cfg_acct_invalid = 1'b1;
   logic [2:0]  cfg_bound_count = '0;
   logic [63:0] cfg_bound [MAX_B] = '{default: '0};

   logic [63:0] ok_count [NUM_T] = '{default: '0};
   logic [63:0] failed_count [NUM_T] = '{default: '0};
   logic [63:0] invalid_count [NUM_T] = '{default: '0};
   logic [63:0] merged_count [NUM_T] = '{default: '0};
   logic [63:0] bytes_total [NUM_T] = '{default: '0};
   logic [63:0] latency_total [NUM_T] = '{default: '0};
   logic [63:0] bin_tally [NUM_T][BIN_SLOTS] = '{default: '{default: '0}};
   logic [63:0] last_access_ns = '0;

   iolh_pkg::iolh_rsp_type expected_rsp [$];

   io_latency_histogram_accounting #(
      .NUM_TYPES (NUM_T),
      .MAX_BOUNDS(MAX_B)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic iolh_pkg::iolh_rsp_type account_request(
      input iolh_pkg::iolh_req_type r);
      iolh_pkg::iolh_rsp_type rsp;
      logic [63:0]  latency;
      int unsigned  t;
      int unsigned  k;
      int unsigned  b;
      int           i;
      rsp = '0;
      t = r.io_type;
      if (r.io_type >= NUM_T ||
          (r.io_type == iolh_pkg::TYPE_NONE &&
           (r.mode == iolh_pkg::MODE_OK || r.mode == iolh_pkg::MODE_FAILED))) begin
         rsp.ignored = 1'b1;
         rsp.last_access = last_access_ns;
         return rsp;
      end
      case (r.mode) inside
         iolh_pkg::MODE_OK, iolh_pkg::MODE_FAILED: begin
            latency = r.now_time - r.start_time;
            k = (cfg_bound_count > MAX_B) ? MAX_B : cfg_bound_count;
            if (r.mode == iolh_pkg::MODE_FAILED) begin
               failed_count[t] += 64'd1;
               rsp.event_count = failed_count[t];
            end else begin
               bytes_total[t] += 64'(r.byte_count);
               ok_count[t] += 64'd1;
               rsp.event_count = ok_count[t];
            end
            if (k != 0) begin
               b = k;
               for (i = int'(k) - 1; i >= 0; i--) begin
                  if (latency < cfg_bound[i]) begin
                     b = i;
                  end
               end
               bin_tally[t][b] += 64'd1;
               rsp.bin_hit = 1'b1;
               rsp.bin_index = 3'(b);
               rsp.bin_value = bin_tally[t][b];
            end
            if (r.mode == iolh_pkg::MODE_OK || cfg_acct_failed) begin
               latency_total[t] += latency;
               last_access_ns = r.now_time;
            end
         end
         iolh_pkg::MODE_INVALID: begin
            invalid_count[t] += 64'd1;
            rsp.event_count = invalid_count[t];
            if (cfg_acct_invalid) begin
               last_access_ns = r.now_time;
            end
         end
         default: begin
            merged_count[t] += 64'(r.merge_count);
            rsp.event_count = merged_count[t];
         end
      endcase
      rsp.byte_total = bytes_total[t];
      rsp.time_total = latency_total[t];
      rsp.last_access = last_access_ns;
      return rsp;
   endfunction

   function automatic iolh_pkg::iolh_req_type make_request(
      input iolh_pkg::iolh_mode_type mode,
      input logic [2:0] io_type,
      input logic [31:0] byte_count,
      input logic [63:0] start_time,
      input logic [63:0] latency,
      input logic [15:0] merge_count);
      iolh_pkg::iolh_req_type r;
      r.mode = mode;
      r.io_type = io_type;
      r.byte_count = byte_count;
      r.start_time = start_time;
      r.now_time = start_time + latency;
      r.merge_count = merge_count;
      return r;
   endfunction

   function automatic iolh_pkg::iolh_req_type random_request();
      iolh_pkg::iolh_mode_type mode;
      logic [2:0]    io_type;
      logic [31:0]   byte_count;
      logic [63:0]   latency;
      logic [15:0]   merge_count;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         mode = iolh_pkg::MODE_OK;
      end else if (pick < 70) begin
         mode = iolh_pkg::MODE_FAILED;
      end else if (pick < 85) begin
         mode = iolh_pkg::MODE_INVALID;
      end else begin
         mode = iolh_pkg::MODE_MERGED;
      end
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
         io_type = 3'($urandom_range(TYPE_READ, TYPE_UNMAP));
      end else if (pick < 94) begin
         io_type = iolh_pkg::TYPE_NONE;
      end else begin
         io_type = 3'($urandom_range(TYPE_UNKNOWN_LO, TYPE_UNKNOWN_HI));
      end
      byte_count = ($urandom_range(0, 99) < 15) ? $urandom : 32'($urandom_range(0, 65536));
      merge_count = ($urandom_range(0, 99) < 20) ? 16'($urandom) : 16'($urandom_range(0, 64));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         latency = cfg_bound[$urandom_range(0, MAX_B - 1)] - 64'd2 + 64'($urandom_range(0, 4));
      end else if (pick < 70) begin
         latency = 64'($urandom_range(0, 20000));
      end else if (pick < 90) begin
         latency = {$urandom, $urandom};
      end else begin
         latency = ($urandom_range(0, 1) != 0) ? MAX_NS : 64'd0;
      end
      return make_request(mode, io_type, byte_count, {$urandom, $urandom}, latency,
                          merge_count);
   endfunction

   task automatic write_csr(input logic [2:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         iolh_pkg::CSR_ACCT_FAILED:  cfg_acct_failed = value[0];
         iolh_pkg::CSR_ACCT_INVALID: cfg_acct_invalid = value[0];
         iolh_pkg::CSR_BOUND_COUNT:  cfg_bound_count = value[2:0];
         default:                    cfg_bound[index - iolh_pkg::CSR_BOUND_A] = value;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_config(input logic acct_failed, input logic acct_invalid,
                                 input logic [2:0] bound_count,
                                 input logic [63:0] bound_ns [MAX_B]);
      write_csr(iolh_pkg::CSR_ACCT_FAILED, 64'(acct_failed));
      write_csr(iolh_pkg::CSR_ACCT_INVALID, 64'(acct_invalid));
      write_csr(iolh_pkg::CSR_BOUND_COUNT, 64'(bound_count));
      write_csr(iolh_pkg::CSR_BOUND_A, bound_ns[0]);
      write_csr(CSR_BOUND_B, bound_ns[1]);
      write_csr(CSR_BOUND_C, bound_ns[2]);
      write_csr(CSR_BOUND_D, bound_ns[3]);
      write_csr(CSR_BOUND_E, bound_ns[4]);
   endtask

   task automatic send_request(input iolh_pkg::iolh_req_type r);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(account_request(r));
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic test_dropped_requests();
      send_request(make_request(iolh_pkg::MODE_OK, iolh_pkg::TYPE_NONE, 32'd512, 64'd1000,
                                64'd50, 16'd0));
      send_request(make_request(iolh_pkg::MODE_FAILED, iolh_pkg::TYPE_NONE, 32'd0, 64'd2000,
                                64'd7, 16'd3));
      send_request(make_request(iolh_pkg::MODE_INVALID, iolh_pkg::TYPE_NONE, 32'd0, 64'd3000,
                                64'd0, 16'd0));
      send_request(make_request(iolh_pkg::MODE_MERGED, iolh_pkg::TYPE_NONE, 32'd0, 64'd0,
                                64'd0, 16'hFFFF));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_UNKNOWN_HI, 32'd64, 64'd10, 64'd5,
                                16'd0));
      send_request(make_request(iolh_pkg::MODE_INVALID, TYPE_UNKNOWN_LO, 32'd0, 64'd20, 64'd1,
                                16'd0));
      send_request(make_request(iolh_pkg::MODE_MERGED, TYPE_UNKNOWN_LO + 3'd1, 32'd0, 64'd0,
                                64'd0, 16'd9));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_READ, 32'd4096, 64'd5000, 64'd250,
                                16'd0));
      wait_until_idle();
   endtask

   task automatic test_bin_edges();
      logic [63:0] bound_ns [MAX_B];
      bound_ns = '{64'd100, 64'd200, 64'd300, 64'd400, MAX_NS};
      program_config(1'b1, 1'b1, 3'd5, bound_ns);
      no_idle = 1'b1;
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_WRITE, 32'hFFFF_FFFF, 64'd0, 64'd0,
                                16'd0));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_WRITE, 32'd1, 64'd10, 64'd99, 16'd0));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_WRITE, 32'd1, 64'd10, 64'd100, 16'd0));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_WRITE, 32'd1, 64'd10, 64'd100, 16'd0));
      send_request(make_request(iolh_pkg::MODE_FAILED, TYPE_FLUSH, 32'd0, 64'd10, 64'd400,
                                16'd0));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_UNMAP, 32'd0, MAX_NS, MAX_NS, 16'd0));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_UNMAP, 32'd8, 64'd1, MAX_NS, 16'd0));
      send_request(make_request(iolh_pkg::MODE_MERGED, TYPE_READ, 32'd0, 64'd0, 64'd0,
                                16'hFFFF));
      send_request(make_request(iolh_pkg::MODE_INVALID, TYPE_READ, 32'd0, 64'd777, 64'd0,
                                16'd0));
      no_idle = 1'b0;
      wait_until_idle();
   endtask

   task automatic test_accounting_switches();
      logic [63:0] bound_ns [MAX_B];
      bound_ns = '{64'd0, 64'd50, 64'd5000, 64'd70000, 64'h8000_0000_0000_0000};
      program_config(1'b0, 1'b0, 3'd7, bound_ns);
      send_request(make_request(iolh_pkg::MODE_FAILED, TYPE_READ, 32'd100, 64'd900, 64'd60,
                                16'd0));
      send_request(make_request(iolh_pkg::MODE_INVALID, TYPE_WRITE, 32'd0, 64'd123456, 64'd0,
                                16'd0));
      send_request(make_request(iolh_pkg::MODE_OK, TYPE_FLUSH, 32'd0, 64'd40,
                                64'h9000_0000_0000_0000, 16'd0));
      send_request(make_request(iolh_pkg::MODE_MERGED, TYPE_UNMAP, 32'd0, 64'd0, 64'd0,
                                16'd17));
      send_request(make_request(iolh_pkg::MODE_FAILED, TYPE_UNMAP, 32'd0, 64'd5, 64'd10,
                                16'd0));
      wait_until_idle();
   endtask

   task automatic program_random_config(input int phase);
      logic [63:0] bound_ns [MAX_B];
      logic [2:0]  bound_count;
      logic        acct_failed;
      logic        acct_invalid;
      int          i;
      acct_failed = 1'($urandom_range(0, 1));
      acct_invalid = 1'($urandom_range(0, 1));
      bound_ns[0] = (phase == 4) ? 64'd0 : 64'($urandom_range(0, 300));
      for (i = 1; i < MAX_B; i++) begin
         bound_ns[i] = bound_ns[i - 1] + 64'($urandom_range(1, 3000));
      end
      case (phase)
         0: begin
            bound_count = 3'd0;
            acct_failed = 1'b0;
            acct_invalid = 1'b0;
         end
         1: begin
            bound_count = 3'd5;
            acct_failed = 1'b1;
            acct_invalid = 1'b1;
            bound_ns[4] = MAX_NS;
         end
         2: bound_count = 3'd7;
         3: begin
            bound_count = 3'd5;
            for (i = 0; i < MAX_B; i++) begin
               bound_ns[i] = {$urandom, $urandom};
            end
         end
         5: bound_count = 3'd1;
         default: bound_count = 3'($urandom_range(1, 6));
      endcase
      program_config(acct_failed, acct_invalid, bound_count, bound_ns);
   endtask

   task automatic test_random_traffic();
      int phase;
      int n;
      for (phase = 0; phase < 6; phase++) begin
         program_random_config(phase);
         for (n = 0; n < 280; n++) begin
            no_idle = (phase == 2 && n < 100);
            send_request(random_request());
         end
         no_idle = 1'b0;
         wait_until_idle();
      end
   endtask

   task automatic test_backpressure();
      int n;
      long_hold = 1'b1;
      for (n = 0; n < 120; n++) begin
         send_request(random_request());
      end
      wait_until_idle();
   endtask

   initial begin
      int unsigned hold;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         hold = no_idle ? 0 : $urandom_range(0, 3);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      iolh_pkg::iolh_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t ns: response expected none actual %0h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("ignored", 64'(want.ignored), 64'(rsp_data.ignored));
            check_field("bin_hit", 64'(want.bin_hit), 64'(rsp_data.bin_hit));
            check_field("bin_index", 64'(want.bin_index), 64'(rsp_data.bin_index));
            check_field("bin_value", want.bin_value, rsp_data.bin_value);
            check_field("event_count", want.event_count, rsp_data.event_count);
            check_field("byte_total", want.byte_total, rsp_data.byte_total);
            check_field("time_total", want.time_total, rsp_data.time_total);
            check_field("last_access", want.last_access, rsp_data.last_access);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("io_latency_histogram_accounting_tb: errors");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_dropped_requests();
      test_bin_edges();
      test_accounting_switches();
      test_random_traffic();
      test_backpressure();
      if (expected_rsp.size() != 0) begin
         $display("%0t ns: responses expected %0d actual 0", $time, expected_rsp.size());
         errors++;
      end
      if (errors == 0) begin
         $display("io_latency_histogram_accounting_tb: clean");
      end else begin
         $display("io_latency_histogram_accounting_tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/iolh_pkg.sv
rtl/core/iolh_bin_sel.sv
rtl/core/iolh_bin_ram.sv
rtl/core/iolh_stats.sv
rtl/core/io_latency_histogram_accounting.sv
rtl/core/iolh_checker.sv
sim/io_latency_histogram_accounting_tb.sv
